@@ rtl/psla_pkg.sv @@
// Package with types and constants shared by the packet serial link adapter.
`default_nettype none
package psla_pkg;
	localparam int RX_DEPTH = 256;
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int RX_MIN_FREE = 32;
	localparam int FRAME_MAX = 32;
	localparam int FR_AW = $clog2(FRAME_MAX);
	localparam int LEN_W = FR_AW + 1;
	localparam int POWER_STEPS = 4;

	localparam logic [RX_AW-1:0] RX_REFUSE_FILL = RX_AW'(RX_DEPTH - RX_MIN_FREE);
	localparam logic [RX_AW-1:0] RX_STORE_MAX = RX_AW'(RX_DEPTH - 1);
	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(FRAME_MAX);
	localparam logic [2:0] STEP_LAST = 3'(POWER_STEPS);

	typedef enum logic [1:0] {
		REQ_RX = 2'd0,
		REQ_READ = 2'd1,
		REQ_WRITE = 2'd2,
		REQ_OUTCOME = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		KIND_READ_DATA = 3'd0,
		KIND_READ_EMPTY = 3'd1,
		KIND_FRAME = 3'd2,
		KIND_WRITE_OK = 3'd3,
		KIND_SENT = 3'd4,
		KIND_FAILED = 3'd5,
		KIND_REFUSED = 3'd6,
		KIND_BUSY = 3'd7
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RING_RD,
		ST_EMIT_RD,
		ST_EMIT_OUT,
		ST_EMIT_WAIT,
		ST_FINAL
	} state_t;

	localparam logic CFG_FLUSH_SIZE = 1'b0;
	localparam logic CFG_PA_DEFAULT = 1'b1;
endpackage
`default_nettype wire

@@ rtl/psla_ram.sv @@
// Generic single write port RAM with registered read.
`default_nettype none
module psla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ rtl/packet_serial_link_adapter_unit.sv @@
// Top level of the packet serial link adapter: receive ring, transmit frame and retry sequencer.
// Simple items load their result into the output register when they are accepted.
// A ring read loads the byte from the ring RAM's registered read in a separate ring read state.
// A frame emission reads, outputs and holds each byte until taken, then any pending result.
// The next item is taken once the output register is empty and the sequencer is idle.
// Reset sets all control state to defaults; ring and frame contents stay undefined until written.
`default_nettype none
module packet_serial_link_adapter_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [5:0] cfg_data,
	input wire logic in_valid,
	output logic in_ready,
	input wire logic [1:0] req_type,
	input wire logic [7:0] data_byte,
	input wire logic packet_first,
	input wire logic packet_last,
	input wire logic send_acked,
	output logic out_valid,
	input wire logic out_ready,
	output logic [2:0] result_kind,
	output logic [7:0] out_byte,
	output logic frame_last,
	output logic [1:0] pa_level,
	output logic [7:0] rx_fill
);
	import psla_pkg::*;

	state_t state_q, state_d;
	logic [RX_AW-1:0] rx_head_q, rx_head_d, rx_tail_q, rx_tail_d, fill;
	logic [7:0] rx_seq_q, rx_seq_d, tx_seq_q, tx_seq_d;
	logic rx_drop_q, rx_drop_d, listen_q, listen_d, await_q, await_d;
	logic [LEN_W-1:0] tx_len_q, tx_len_d, len_eff, limit;
	logic [1:0] pa_q, pa_d, pa_def_q;
	logic round_q, round_d;
	logic [2:0] step_q, step_d;
	logic [5:0] flush_q;
	logic [FR_AW-1:0] emit_idx_q, emit_idx_d, tx_waddr;
	logic fin_pend_q, fin_pend_d;
	kind_t fin_kind_q, fin_kind_d, ld_kind;
	logic out_valid_q, out_load, ld_last, emit_last;
	logic [7:0] ld_byte, ring_rdata, tx_rdata, seq_next;
	logic ring_we, tx_we;
	kind_t out_kind_q;
	logic [7:0] out_byte_q, out_fill_q;
	logic out_last_q;
	logic [1:0] out_pa_q;

	psla_ram #(.WIDTH(8), .DEPTH(RX_DEPTH)) u_rx_ring (
		.clk(clk), .we(ring_we), .waddr(rx_head_q), .wdata(data_byte),
		.raddr(rx_tail_q), .rdata(ring_rdata)
	);

	psla_ram #(.WIDTH(8), .DEPTH(FRAME_MAX)) u_tx_frame (
		.clk(clk), .we(tx_we), .waddr(tx_waddr), .wdata(data_byte),
		.raddr(emit_idx_q), .rdata(tx_rdata)
	);

	assign fill = rx_head_q - rx_tail_q;
	assign in_ready = (state_q == ST_IDLE) && !out_valid_q;
	assign limit = (flush_q > LEN_MAX) ? LEN_MAX : flush_q;
	assign len_eff = (tx_len_q >= LEN_MAX) ? LEN_W'(1) : tx_len_q;
	assign tx_waddr = len_eff[FR_AW-1:0];
	assign emit_last = ({1'b0, emit_idx_q} == tx_len_q - LEN_W'(1));
	assign seq_next = (tx_seq_q == 8'hFF) ? 8'd1 : tx_seq_q + 8'd1;

	always_comb begin
		state_d = state_q;
		rx_head_d = rx_head_q;
		rx_tail_d = rx_tail_q;
		rx_seq_d = rx_seq_q;
		rx_drop_d = rx_drop_q;
		tx_len_d = tx_len_q;
		tx_seq_d = tx_seq_q;
		listen_d = listen_q;
		pa_d = pa_q;
		round_d = round_q;
		step_d = step_q;
		await_d = await_q;
		emit_idx_d = emit_idx_q;
		fin_pend_d = fin_pend_q;
		fin_kind_d = fin_kind_q;
		ring_we = 1'b0;
		tx_we = 1'b0;
		out_load = 1'b0;
		ld_kind = KIND_READ_DATA;
		ld_byte = 8'd0;
		ld_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid && in_ready) begin
					unique case (req_t'(req_type))
						REQ_RX: begin
							if (await_q) begin
								rx_drop_d = 1'b1;
							end else begin
								if (packet_first) begin
									if (fill > RX_REFUSE_FILL) begin
										rx_drop_d = 1'b1;
										out_load = 1'b1;
										ld_kind = KIND_REFUSED;
									end else if (data_byte == rx_seq_q) begin
										rx_drop_d = 1'b1;
									end else begin
										rx_seq_d = rx_seq_q + 8'd1;
										rx_drop_d = 1'b0;
									end
								end else if (!rx_drop_q && fill < RX_STORE_MAX) begin
									ring_we = 1'b1;
									rx_head_d = rx_head_q + RX_AW'(1);
								end
								if (packet_last) begin
									rx_drop_d = 1'b1;
								end
							end
						end
						REQ_OUTCOME: begin
							if (await_q) begin
								if (send_acked) begin
									tx_len_d = LEN_W'(1);
									listen_d = 1'b1;
									round_d = 1'b0;
									step_d = 3'd0;
									await_d = 1'b0;
									out_load = 1'b1;
									ld_kind = KIND_SENT;
								end else if (step_q < STEP_LAST) begin
									pa_d = step_q[1:0];
									step_d = step_q + 3'd1;
									emit_idx_d = '0;
									fin_pend_d = 1'b0;
									state_d = ST_EMIT_RD;
								end else if (!round_q) begin
									round_d = 1'b1;
									step_d = 3'd0;
									emit_idx_d = '0;
									fin_pend_d = 1'b0;
									state_d = ST_EMIT_RD;
								end else begin
									pa_d = pa_def_q;
									tx_len_d = LEN_W'(1);
									listen_d = 1'b1;
									round_d = 1'b0;
									step_d = 3'd0;
									await_d = 1'b0;
									out_load = 1'b1;
									ld_kind = KIND_FAILED;
								end
							end
						end
						REQ_READ, REQ_WRITE: begin
							if (await_q) begin
								out_load = 1'b1;
								ld_kind = KIND_BUSY;
							end else if (req_t'(req_type) == REQ_READ) begin
								if (tx_len_q > LEN_W'(1)) begin
									fin_kind_d = KIND_READ_EMPTY;
									fin_pend_d = 1'b1;
									tx_seq_d = seq_next;
									listen_d = 1'b0;
									rx_tail_d = rx_head_q;
									round_d = 1'b0;
									step_d = 3'd0;
									await_d = 1'b1;
									emit_idx_d = '0;
									state_d = ST_EMIT_RD;
								end else if (fill != '0) begin
									rx_tail_d = rx_tail_q + RX_AW'(1);
									state_d = ST_RING_RD;
								end else begin
									out_load = 1'b1;
									ld_kind = KIND_READ_EMPTY;
								end
							end else begin
								if (listen_q || tx_len_q <= LEN_W'(1)) begin
									listen_d = 1'b0;
									rx_tail_d = rx_head_q;
								end
								tx_we = 1'b1;
								tx_len_d = len_eff + LEN_W'(1);
								if (tx_len_d >= limit) begin
									fin_kind_d = KIND_WRITE_OK;
									fin_pend_d = 1'b1;
									tx_seq_d = seq_next;
									listen_d = 1'b0;
									rx_tail_d = rx_head_q;
									round_d = 1'b0;
									step_d = 3'd0;
									await_d = 1'b1;
									emit_idx_d = '0;
									state_d = ST_EMIT_RD;
								end else begin
									out_load = 1'b1;
									ld_kind = KIND_WRITE_OK;
								end
							end
						end
					endcase
				end
			end
			ST_RING_RD: begin
				out_load = 1'b1;
				ld_kind = KIND_READ_DATA;
				ld_byte = ring_rdata;
				state_d = ST_IDLE;
			end
			ST_EMIT_RD: begin
				state_d = ST_EMIT_OUT;
			end
			ST_EMIT_OUT: begin
				out_load = 1'b1;
				ld_kind = KIND_FRAME;
				ld_byte = (emit_idx_q == '0) ? tx_seq_q : tx_rdata;
				ld_last = emit_last;
				state_d = ST_EMIT_WAIT;
			end
			ST_EMIT_WAIT: begin
				if (out_ready) begin
					if (emit_last) begin
						state_d = fin_pend_q ? ST_FINAL : ST_IDLE;
					end else begin
						emit_idx_d = emit_idx_q + FR_AW'(1);
						state_d = ST_EMIT_RD;
					end
				end
			end
			ST_FINAL: begin
				out_load = 1'b1;
				ld_kind = fin_kind_q;
				fin_pend_d = 1'b0;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rx_head_q <= '0;
			rx_tail_q <= '0;
			rx_seq_q <= '0;
			rx_drop_q <= 1'b0;
			tx_len_q <= LEN_W'(1);
			tx_seq_q <= '0;
			listen_q <= 1'b0;
			pa_q <= 2'd2;
			round_q <= 1'b0;
			step_q <= '0;
			await_q <= 1'b0;
			emit_idx_q <= '0;
			fin_pend_q <= 1'b0;
			fin_kind_q <= KIND_READ_EMPTY;
			out_valid_q <= 1'b0;
			flush_q <= 6'd32;
			pa_def_q <= 2'd2;
		end else begin
			state_q <= state_d;
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			rx_seq_q <= rx_seq_d;
			rx_drop_q <= rx_drop_d;
			tx_len_q <= tx_len_d;
			tx_seq_q <= tx_seq_d;
			listen_q <= listen_d;
			pa_q <= pa_d;
			round_q <= round_d;
			step_q <= step_d;
			await_q <= await_d;
			emit_idx_q <= emit_idx_d;
			fin_pend_q <= fin_pend_d;
			fin_kind_q <= fin_kind_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_FLUSH_SIZE: flush_q <= cfg_data;
					CFG_PA_DEFAULT: pa_def_q <= cfg_data[1:0];
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= ld_kind;
			out_byte_q <= ld_byte;
			out_last_q <= ld_last;
			out_pa_q <= pa_d;
			out_fill_q <= 8'(rx_head_d - rx_tail_d);
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = out_kind_q;
	assign out_byte = out_byte_q;
	assign frame_last = out_last_q;
	assign pa_level = out_pa_q;
	assign rx_fill = out_fill_q;

`ifndef ASSERT_OFF
	a_await_has_frame: assert property (@(posedge clk) disable iff (!arst_n)
		await_q |-> (tx_len_q > LEN_W'(1)))
		else $error("outcome awaited without a pending frame");
	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_LAST)
		else $error("power step beyond schedule");
	a_seq_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		await_q |-> (tx_seq_q != 8'd0))
		else $error("transmit counter zero during send");
	a_emit_no_input: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_WAIT) |-> (out_valid_q && !in_ready))
		else $error("frame beat not held in output register");
`endif
endmodule
`default_nettype wire
